>>> rtl/core/obt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package obt_pkg;

    // Book geometry and field widths
    localparam int BOOK_DEPTH  = 8;
    localparam int CNT_W       = $clog2(BOOK_DEPTH + 1);
    localparam int OP_W        = 2;
    localparam int STOCK_W     = 2;
    localparam int ID_W        = 31;
    localparam int PRICE_W     = 31;
    localparam int QTY_W       = 31;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 4;

    // Only this book is kept
    localparam logic [STOCK_W-1:0] KEPT_STOCK = '0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_DECREASE = 2'd1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_DECREASED = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [STOCK_W-1:0] book_sel;
        logic [ID_W-1:0]    order_ref;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [PRICE_W-1:0]     best_price;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [QTY_W-1:0]       remaining_quantity;
    } t_out_item;

    // One table entry held by a cell
    typedef struct packed {
        logic [ID_W-1:0]    order_ref;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } t_entry;

    // Command broadcast to every cell in the execute cycle
    typedef struct packed {
        logic               do_add;
        logic               do_dec;
        logic [ID_W-1:0]    order_ref;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } t_cell_cmd;

    // Search result passed from each cell to its right-hand neighbour
    typedef struct packed {
        logic found;
        logic remove;
    } t_chain;

endpackage

`default_nettype wire

>>> rtl/core/obt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module obt_cell (
    input  wire logic                      i_clk,
    input  wire obt_pkg::t_cell_cmd        i_cmd,
    input  wire logic                      i_active,
    input  wire logic                      i_tail,
    input  wire obt_pkg::t_chain           i_chain,
    output obt_pkg::t_chain                o_chain,
    input  wire obt_pkg::t_entry           i_next,
    output obt_pkg::t_entry                o_entry,
    output logic [obt_pkg::QTY_W-1:0]      o_left
);
    import obt_pkg::*;

    t_entry           r_entry;
    t_entry           n_entry;
    logic             match;
    logic             hit;
    logic             short;
    logic             shift;
    logic [QTY_W-1:0] diff;

    // Compare this entry against the request and decide its role
    always_comb begin
        match = i_cmd.do_dec & i_active & (r_entry.order_ref == i_cmd.order_ref);
        hit   = match & ~i_chain.found;
        short = r_entry.quantity < i_cmd.quantity;
        diff  = r_entry.quantity - i_cmd.quantity;
        shift = (i_chain.found & i_chain.remove) | (hit & short);
    end

    // Pass the first-match result on to the next cell
    always_comb begin
        o_chain.found  = i_chain.found | match;
        o_chain.remove = i_chain.found ? i_chain.remove : (hit & short);
        o_left         = (hit & ~short) ? diff : '0;
    end

    // Next entry: load at the tail, take the neighbour on removal, or reduce
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.do_add && i_tail) begin
            n_entry.order_ref = i_cmd.order_ref;
            n_entry.price     = i_cmd.price;
            n_entry.quantity  = i_cmd.quantity;
        end else if (shift) begin
            n_entry = i_next;
        end else if (hit) begin
            n_entry.quantity = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> rtl/core/order_book_table.sv
// Order book table for a single stock.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries add and
// decrease requests; the output channel (o_out_valid / i_out_ready /
// o_out_data) returns exactly one result per request, in order.
// A transfer on the input is registered, and in the execute step the row
// of cells compares every held id at once, resolves the first match along
// the cell chain, and either appends, reduces or removes an entry, shifting
// later entries down by one place in that same cycle.
// The request register holds the input and the result register holds the
// outcome; the register-then-execute sequence around the cell row keeps
// one request in flight at a time, so no new request is taken before it ends.
// The input is ready while the output register still holds an unread result;
// a request waits in its execute step until the output register is free, so
// a stalled receiver holds its result unchanged and eventually stops input.
// Reset empties the book, clears the best price to zero and drops any
// pending result; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module order_book_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire obt_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output obt_pkg::t_out_item      o_out_data
);
    import obt_pkg::*;

    t_state               r_state;
    t_state               n_state;
    t_in_item             r_req;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [PRICE_W-1:0]   r_top_price;
    logic [PRICE_W-1:0]   n_top_price;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic                 go;
    logic                 in_xfer;
    logic                 kept;
    logic                 is_add;
    logic                 is_dec;
    logic                 full;
    t_status              status;
    t_cell_cmd            cmd;
    logic [QTY_W-1:0]     left;
    t_chain               chain [BOOK_DEPTH+1];
    t_entry               entry [BOOK_DEPTH];
    logic [QTY_W-1:0]     cell_left [BOOK_DEPTH];

    // Decode the registered request
    always_comb begin
        kept   = (r_req.book_sel == KEPT_STOCK);
        is_add = kept & (r_req.opcode == OP_ADD);
        is_dec = kept & (r_req.opcode == OP_DECREASE);
        full   = (r_count == CNT_W'(BOOK_DEPTH));
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        go         = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_EXEC:  go = ~r_out_valid | i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                go         = 1'b0;
            end
        endcase
    end

    assign in_xfer = i_in_valid & o_in_ready;

    // Command broadcast to the cell row
    always_comb begin
        cmd.do_add    = go & is_add & ~full;
        cmd.do_dec    = go & is_dec;
        cmd.order_ref = r_req.order_ref;
        cmd.price     = r_req.price;
        cmd.quantity  = r_req.quantity;
    end

    assign chain[0] = '{found: 1'b0, remove: 1'b0};

    // Row of cells, each handing its entry down to the left on removal
    for (genvar k = 0; k < BOOK_DEPTH; k++) begin : g_cell
        t_entry next_entry;

        if (k == BOOK_DEPTH - 1) begin : g_last
            assign next_entry = entry[k];
        end else begin : g_mid
            assign next_entry = entry[k+1];
        end

        obt_cell u_cell (
            .i_clk    (i_clk),
            .i_cmd    (cmd),
            .i_active (CNT_W'(k) < r_count),
            .i_tail   (CNT_W'(k) == r_count),
            .i_chain  (chain[k]),
            .o_chain  (chain[k+1]),
            .i_next   (next_entry),
            .o_entry  (entry[k]),
            .o_left   (cell_left[k])
        );
    end

    // Remaining quantity comes from the single matching cell, zero elsewhere
    always_comb begin
        left = '0;
        for (int k = 0; k < BOOK_DEPTH; k++) begin
            left = left | cell_left[k];
        end
    end

    // Status, count and best price after this request
    always_comb begin
        status      = ST_IGNORED;
        n_count     = r_count;
        n_top_price = r_top_price;
        if (is_add) begin
            if (full) begin
                status = ST_FULL;
            end else begin
                status  = ST_ADDED;
                n_count = r_count + CNT_W'(1);
                if (r_req.price > r_top_price) begin
                    n_top_price = r_req.price;
                end
            end
        end else if (is_dec) begin
            if (!chain[BOOK_DEPTH].found) begin
                status = ST_NOT_FOUND;
            end else if (chain[BOOK_DEPTH].remove) begin
                status  = ST_REMOVED;
                n_count = r_count - CNT_W'(1);
            end else begin
                status = ST_DECREASED;
            end
        end
    end

    // Sequencer and book control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_top_price <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_count     <= n_count;
                r_top_price <= n_top_price;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_in_data;
        end
        if (go) begin
            r_out_data.status             <= status;
            r_out_data.best_price         <= n_top_price;
            r_out_data.entry_count        <= COUNT_OUT_W'(n_count);
            r_out_data.remaining_quantity <= (status == ST_DECREASED) ? left : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/core/obt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module obt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire obt_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire obt_pkg::t_out_item o_out_data
);
    import obt_pkg::*;

    // A result held against a stalled receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while receiver stalled");

    // One request at a time: the input closes after each transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a request is in flight");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_IGNORED)
        else $error("undefined status code");

    // Count never exceeds the book depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.entry_count <= COUNT_OUT_W'(BOOK_DEPTH))
        else $error("entry count beyond book depth");

    // Remaining quantity is reported only for a plain decrease
    a_left_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_DECREASED
            |-> o_out_data.remaining_quantity == '0)
        else $error("remaining quantity set on a non-decrease result");

endmodule

bind order_book_table obt_checker u_obt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
